/* rtl/dtm_pkg.sv */
// Shared widths, stage payload types and calendar tables for the date-to-minute converter.
package dtm_pkg;

  localparam int YEAR_W   = 12;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int COUNT_W  = 33;

  localparam int TOD_W  = 11;  // minute of day, 0..1439
  localparam int DOY_W  = 9;   // day of year, 0..365
  localparam int CENT_W = 6;   // year / 100, 0..40
  localparam int REM_W  = 7;   // year % 100
  localparam int DAYS_W = 22;  // signed day count
  localparam int RECIP_W     = 16;
  localparam int RECIP_SHIFT = 22;
  localparam int PROD_W      = YEAR_W + RECIP_W;

  // ceil(2^22 / 100): exact floor(y / 100) for every 12-bit y
  localparam logic [RECIP_W-1:0] RECIP100 = RECIP_W'(41944);

  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

  localparam logic [DAY_W-1:0]    LEAP_DAY     = DAY_W'(29);
  localparam logic [HOUR_W-1:0]   LAST_HOUR    = HOUR_W'(23);
  localparam logic [MINUTE_W-1:0] LAST_MINUTE  = MINUTE_W'(59);
  localparam logic [DAYS_W-1:0]   DAYS_IN_YEAR = DAYS_W'(365);
  localparam logic [TOD_W-1:0]    MIN_PER_HOUR = TOD_W'(60);
  localparam logic signed [COUNT_W-1:0] MIN_PER_DAY = COUNT_W'(1440);

  // stage 1 -> stage 2
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [PROD_W-1:0]  cent_prod;
    logic               base_ok;   // month, day >= 1, hour, minute in range
    logic               len_ok;    // day fits the non-leap month length
    logic               feb29;
    logic               past_feb;
    logic [DOY_W-1:0]   doy;       // days before month plus day - 1
    logic [TOD_W-1:0]   tod;
  } front_t;

  // stage 2 -> stage 3
  typedef struct packed {
    logic               ok;
    logic               year_zero;
    logic [YEAR_W-1:0]  prior;     // year - 1
    logic [CENT_W-1:0]  prior_cent; // prior / 100
    logic [DOY_W-1:0]   doy;
    logic [TOD_W-1:0]   tod;
  } leap_t;

  // stage 3 -> stage 4
  typedef struct packed {
    logic                     ok;
    logic signed [DAYS_W-1:0] days;
    logic [TOD_W-1:0]         tod;
  } days_t;

  function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] d;
    case (m)
      4'd1:    d = DOY_W'(0);
      4'd2:    d = DOY_W'(31);
      4'd3:    d = DOY_W'(59);
      4'd4:    d = DOY_W'(90);
      4'd5:    d = DOY_W'(120);
      4'd6:    d = DOY_W'(151);
      4'd7:    d = DOY_W'(181);
      4'd8:    d = DOY_W'(212);
      4'd9:    d = DOY_W'(243);
      4'd10:   d = DOY_W'(273);
      4'd11:   d = DOY_W'(304);
      4'd12:   d = DOY_W'(334);
      default: d = DOY_W'(0);
    endcase
    return d;
  endfunction

  // non-leap length; zero for month codes outside 1..12
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] l;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: l = DAY_W'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                    l = DAY_W'(30);
      4'd2:                                       l = DAY_W'(28);
      default:                                    l = DAY_W'(0);
    endcase
    return l;
  endfunction

endpackage

/* rtl/dtm_in_if.sv */
// Input channel: one calendar timestamp per beat.
interface dtm_in_if
  import dtm_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [YEAR_W-1:0]   year;
  logic [MONTH_W-1:0]  month;
  logic [DAY_W-1:0]    day;
  logic [HOUR_W-1:0]   hour;
  logic [MINUTE_W-1:0] minute;

  modport source (output valid, year, month, day, hour, minute, input ready);
  modport sink   (input valid, year, month, day, hour, minute, output ready);
endinterface

/* rtl/dtm_out_if.sv */
// Output channel: check flag and minute count per beat.
interface dtm_out_if
  import dtm_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic                      stamp_ok;
  logic signed [COUNT_W-1:0] minute_count;

  modport source (output valid, stamp_ok, minute_count, input ready);
  modport sink   (input valid, stamp_ok, minute_count, output ready);
endinterface

/* rtl/dtm_front.sv */
// Stage 1: field range checks, month table lookup, minute of day, year / 100 product.
module dtm_front
  import dtm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [YEAR_W-1:0]   year,
  input  logic [MONTH_W-1:0]  month,
  input  logic [DAY_W-1:0]    day,
  input  logic [HOUR_W-1:0]   hour,
  input  logic [MINUTE_W-1:0] minute,
  output logic                out_valid,
  input  logic                out_ready,
  output front_t              out_data
);

  front_t data_next;

  always_comb begin
    data_next.year      = year;
    data_next.cent_prod = PROD_W'(year) * PROD_W'(RECIP100);
    data_next.base_ok   = (month >= MONTH_JAN) && (month <= MONTH_DEC) && (day != '0) &&
                          (hour <= LAST_HOUR) && (minute <= LAST_MINUTE);
    data_next.len_ok    = day <= month_len(month);
    data_next.feb29     = (month == MONTH_FEB) && (day == LEAP_DAY);
    data_next.past_feb  = month > MONTH_FEB;
    data_next.doy       = days_before(month) + DOY_W'(day) - DOY_W'(1);
    data_next.tod       = TOD_W'(hour) * MIN_PER_HOUR + TOD_W'(minute);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

/* rtl/dtm_leap.sv */
// Stage 2: century split, leap-year rule, final validity and day of year.
module dtm_leap
  import dtm_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  front_t in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output leap_t  out_data
);

  logic [CENT_W-1:0] cent;
  logic [YEAR_W-1:0] cent_x100;
  logic [REM_W-1:0]  cent_rem;
  logic              century;
  logic              leap;
  logic              year_zero;
  leap_t             data_next;

  always_comb begin
    cent      = in_data.cent_prod[RECIP_SHIFT +: CENT_W];
    cent_x100 = (YEAR_W'(cent) << 6) + (YEAR_W'(cent) << 5) + (YEAR_W'(cent) << 2);
    cent_rem  = REM_W'(in_data.year - cent_x100);
    century   = cent_rem == '0;
    year_zero = in_data.year == '0;
    // div by 400 <=> century with year / 100 div by 4
    leap      = (in_data.year[1:0] == 2'b00) && (!century || (cent[1:0] == 2'b00));

    data_next.ok         = in_data.base_ok && (in_data.len_ok || (in_data.feb29 && leap));
    data_next.year_zero  = year_zero;
    data_next.prior      = in_data.year - YEAR_W'(1);
    // floor((y-1)/100) drops by one exactly when y is a century year
    data_next.prior_cent = year_zero ? '0 : cent - CENT_W'(century);
    data_next.doy        = in_data.doy + DOY_W'(in_data.past_feb && leap);
    data_next.tod        = in_data.tod;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

/* rtl/dtm_days.sv */
// Stage 3: day count from earlier years, their leap days and the day of year.
module dtm_days
  import dtm_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  leap_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output days_t out_data
);

  logic [DAYS_W-1:0] year_days;
  logic [DAYS_W-1:0] leap_days;
  days_t             data_next;

  always_comb begin
    year_days = DAYS_W'(in_data.prior) * DAYS_IN_YEAR;
    leap_days = DAYS_W'(in_data.prior >> 2) - DAYS_W'(in_data.prior_cent)
              + DAYS_W'(in_data.prior_cent >> 2);
    data_next.ok  = in_data.ok;
    data_next.tod = in_data.tod;
    // year zero: one earlier year of 365 days counted backward, no leap days
    if (in_data.year_zero) begin
      data_next.days = $signed(DAYS_W'(in_data.doy) - DAYS_IN_YEAR);
    end else begin
      data_next.days = $signed(year_days + leap_days + DAYS_W'(in_data.doy));
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

/* rtl/dtm_scale.sv */
// Stage 4: days to minutes, invalid stamps forced to zero; holds the output beat.
module dtm_scale
  import dtm_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  days_t                     in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      stamp_ok,
  output logic signed [COUNT_W-1:0] minute_count
);

  logic signed [COUNT_W-1:0] days_ext;
  logic signed [COUNT_W-1:0] total;

  always_comb begin
    days_ext = COUNT_W'(in_data.days);
    total    = days_ext * MIN_PER_DAY + $signed(COUNT_W'(in_data.tod));
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stamp_ok     <= in_data.ok;
      minute_count <= in_data.ok ? total : '0;
    end
  end

endmodule

/* rtl/date_to_minute_count.sv */
// Gregorian timestamp checker and converter to minutes since 0001-01-01 00:00.
//
// Channels: stamp (sink) takes year, month, day, hour and minute; result
// (source) gives stamp_ok and the signed 33-bit minute_count. A beat moves
// when valid and ready are both high.
// Four register stages (range checks and year/100 product, leap rule, day
// count, scaling to minutes) lie between an accepted stamp beat and its
// result beat; each hands off through its own valid bit. Throughput: one
// stamp per cycle while result.ready is high.
// An invalid stamp gives stamp_ok low and minute_count zero. Year 0 gives
// a negative count, but for December 31, whose count is not negative.
// Reset (rst, synchronous) empties every stage; stamp.ready is high right
// after it.
// When result.ready is low the last stage holds its beat; earlier stages keep
// taking stamps until the pipeline is full, then stamp.ready drops. No beat
// is lost or repeated across a stall.
module date_to_minute_count
  import dtm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  dtm_in_if.sink      stamp,
  dtm_out_if.source   result
);

  logic   s1_valid, s1_ready;
  logic   s2_valid, s2_ready;
  logic   s3_valid, s3_ready;
  front_t s1_data;
  leap_t  s2_data;
  days_t  s3_data;

  dtm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (stamp.valid),
    .in_ready  (stamp.ready),
    .year      (stamp.year),
    .month     (stamp.month),
    .day       (stamp.day),
    .hour      (stamp.hour),
    .minute    (stamp.minute),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_data  (s1_data)
  );

  dtm_leap u_leap (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_data  (s2_data)
  );

  dtm_days u_days (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .in_data   (s2_data),
    .out_valid (s3_valid),
    .out_ready (s3_ready),
    .out_data  (s3_data)
  );

  dtm_scale u_scale (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s3_valid),
    .in_ready     (s3_ready),
    .in_data      (s3_data),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .stamp_ok     (result.stamp_ok),
    .minute_count (result.minute_count)
  );

endmodule

/* rtl/dtm_checker.sv */
// Port-level checks on the converter, bound to the top level.
module dtm_checker
  import dtm_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      stamp_ok,
  input logic signed [COUNT_W-1:0] minute_count
);

  // result beats only come from accepted stamps; none survive reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(stamp_ok) && $stable(minute_count)))
    else $error("stalled result beat changed");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !stamp_ok) |-> (minute_count == '0))
    else $error("invalid stamp with nonzero count");

  // smallest count is year 0 start, one 365-day year before the epoch
  a_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && stamp_ok) |-> (minute_count >= -COUNT_W'(525600)))
    else $error("minute count below year zero");

endmodule

bind date_to_minute_count dtm_checker u_dtm_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .stamp_ok     (result.stamp_ok),
  .minute_count (result.minute_count)
);

/* verif/date_to_minute_count_tb.sv */
// Testbench for date_to_minute_count: directed and random timestamps checked against a predictor.
`timescale 1ns / 1ps

module date_to_minute_count_tb
  import dtm_pkg::*;
();

  localparam int RANDOM_STAMPS = 500;
  localparam int HOLD_AT       = 150;   // stamps sent before the long result hold
  localparam int HOLD_CYCLES   = 64;
  localparam int DRAIN_AT      = 320;   // random stamp index where the sender drains
  localparam int LIMIT_CYCLES  = 200000;

  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
  } stamp_t;

  typedef struct packed {
    logic                ok;
    logic [COUNT_W-1:0]  count;
  } minutes_t;

  class minute_count_checker;
    minutes_t    expected_counts[int unsigned];
    int unsigned wr_seq;
    int unsigned rd_seq;
    int unsigned mismatches;

    static function bit is_leap(logic [YEAR_W-1:0] y);
      return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    static function int unsigned days_in_month(logic [YEAR_W-1:0] y,
                                               logic [MONTH_W-1:0] m);
      int unsigned len;
      case (m)
        4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 31;
        4'd4, 4'd6, 4'd9, 4'd11:                    len = 30;
        MONTH_FEB:                                  len = is_leap(y) ? 29 : 28;
        default:                                    len = 0;
      endcase
      return len;
    endfunction

    function minutes_t stamp_to_minutes(stamp_t s);
      minutes_t    r;
      longint      prior;
      longint      days;
      longint      total;
      int unsigned m;
      r.ok    = 1'b0;
      r.count = '0;
      // unknown months have length zero, so the day test rejects them too
      if (s.day == 0 || s.day > days_in_month(s.year, s.month) ||
          s.hour > LAST_HOUR || s.minute > LAST_MINUTE)
        return r;
      // signed division truncates toward zero; year 0 gives prior = -1
      prior = longint'(s.year) - 1;
      days  = prior * 365 + prior / 4 - prior / 100 + prior / 400;
      for (m = 1; m < s.month; m++)
        days += longint'(days_in_month(YEAR_W'(1), MONTH_W'(m)));
      if (s.month > MONTH_FEB && is_leap(s.year))
        days += 1;
      days += longint'(s.day) - 1;
      total = days * 1440 + longint'(s.hour) * 60 + longint'(s.minute);
      r.ok    = 1'b1;
      r.count = total[COUNT_W-1:0];
      return r;
    endfunction

    function int unsigned outstanding();
      return wr_seq - rd_seq;
    endfunction

    function void note_stamp(stamp_t s);
      expected_counts[wr_seq] = stamp_to_minutes(s);
      wr_seq++;
    endfunction

    function void check_result(logic ok, logic [COUNT_W-1:0] count);
      minutes_t want;
      if (outstanding() == 0) begin
        if (mismatches < 10)
          $display("unexpected result beat: ok=%0b count=%0d", ok, $signed(count));
        mismatches++;
        return;
      end
      want = expected_counts[rd_seq];
      expected_counts.delete(rd_seq);
      rd_seq++;
      if (want.ok !== ok || want.count !== count) begin
        if (mismatches < 10)
          $display("mismatch: expected ok=%0b count=%0d, got ok=%0b count=%0d",
                   want.ok, $signed(want.count), ok, $signed(count));
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  int unsigned cycles = 0;
  int unsigned stamps_sent = 0;
  bit hold_active = 1'b0;

  minute_count_checker board = new();

  dtm_in_if  stamp_ch();
  dtm_out_if result_ch();

  date_to_minute_count i_dut (
    .clk    (clk),
    .rst    (rst),
    .stamp  (stamp_ch),
    .result (result_ch)
  );

  always #2 clk = ~clk;

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic stamp_t mk_stamp(int unsigned y, int unsigned mo, int unsigned d,
                                      int unsigned h, int unsigned mi);
    stamp_t s;
    s.year   = YEAR_W'(y);
    s.month  = MONTH_W'(mo);
    s.day    = DAY_W'(d);
    s.hour   = HOUR_W'(h);
    s.minute = MINUTE_W'(mi);
    return s;
  endfunction

  function automatic stamp_t random_stamp();
    stamp_t      s;
    int unsigned r;
    int unsigned pick;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0:       s.year = '0;
        1:       s.year = YEAR_W'(1);
        2:       s.year = '1;
        3:       s.year = YEAR_W'($urandom_range(0, 40) * 100);  // century years
        default: s.year = YEAR_W'($urandom);
      endcase
      s.month  = MONTH_W'($urandom_range(1, 12));
      s.day    = DAY_W'($urandom_range(1,
                   minute_count_checker::days_in_month(s.year, s.month)));
      s.hour   = HOUR_W'($urandom_range(0, 23));
      s.minute = MINUTE_W'($urandom_range(0, 59));
      // near misses: push one field just past its limit
      if (r >= 70) begin
        case ($urandom_range(0, 4))
          0: s.day    = DAY_W'(minute_count_checker::days_in_month(s.year, s.month) + 1);
          1: s.hour   = LAST_HOUR + 1'b1;
          2: s.minute = LAST_MINUTE + 1'b1;
          3: s.month  = MONTH_DEC + 1'b1;
          default: s.day = '0;
        endcase
      end
    end else begin
      s = stamp_t'($urandom);
    end
    return s;
  endfunction

  task automatic send_stamp(stamp_t s);
    stamp_ch.valid  <= 1'b1;
    stamp_ch.year   <= s.year;
    stamp_ch.month  <= s.month;
    stamp_ch.day    <= s.day;
    stamp_ch.hour   <= s.hour;
    stamp_ch.minute <= s.minute;
    do @(posedge clk); while (!stamp_ch.ready);
    board.note_stamp(s);
    stamps_sent++;
  endtask

  task automatic send_with_gap(stamp_t s);
    int unsigned gap;
    gap = hold_active ? 0 : pick_gap();
    if (gap > 0) begin
      stamp_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    send_stamp(s);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("date_to_minute_count_tb failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready)
      board.check_result(result_ch.stamp_ok, result_ch.minute_count);
  end

  // result side back-pressure, including one long hold while stamps keep coming
  initial begin
    int unsigned stall;
    bit held;
    held = 1'b0;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && stamps_sent >= HOLD_AT) begin
        held = 1'b1;
        hold_active = 1'b1;
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active = 1'b0;
        result_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          result_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        result_ch.ready <= 1'b1;
        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(20, 50)
                                          : $urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  initial begin
    int     i;
    rst <= 1'b1;
    stamp_ch.valid  <= 1'b0;
    stamp_ch.year   <= '0;
    stamp_ch.month  <= '0;
    stamp_ch.day    <= '0;
    stamp_ch.hour   <= '0;
    stamp_ch.minute <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_with_gap(mk_stamp(0, 1, 1, 0, 0));         // year zero, negative count
    send_with_gap(mk_stamp(0, 2, 29, 12, 30));      // year zero is leap
    send_with_gap(mk_stamp(0, 12, 31, 23, 59));
    send_with_gap(mk_stamp(1, 1, 1, 0, 0));         // epoch
    send_with_gap(mk_stamp(4095, 12, 31, 23, 59));  // largest count
    send_with_gap(mk_stamp(1900, 2, 29, 0, 0));     // century, not leap
    send_with_gap(mk_stamp(2000, 2, 29, 8, 15));
    send_with_gap(mk_stamp(2001, 2, 29, 8, 15));
    send_with_gap(mk_stamp(2004, 3, 1, 0, 0));      // leap day already passed
    send_with_gap(mk_stamp(2100, 3, 1, 0, 0));
    send_with_gap(mk_stamp(2024, 0, 10, 5, 5));
    send_with_gap(mk_stamp(2024, 13, 1, 5, 5));
    send_with_gap(mk_stamp(2024, 15, 31, 31, 63));
    send_with_gap(mk_stamp(2024, 5, 0, 1, 1));
    send_with_gap(mk_stamp(2024, 4, 31, 1, 1));
    send_with_gap(mk_stamp(2024, 1, 31, 1, 1));
    send_with_gap(mk_stamp(2024, 6, 15, 24, 0));
    send_with_gap(mk_stamp(2024, 6, 15, 31, 0));
    send_with_gap(mk_stamp(2024, 6, 15, 0, 60));
    send_with_gap(mk_stamp(2024, 6, 15, 0, 63));
    send_with_gap(mk_stamp(2024, 2, 30, 0, 0));
    send_with_gap(mk_stamp(4000, 2, 29, 23, 59));
    send_with_gap(mk_stamp(0, 0, 0, 0, 0));
    send_with_gap(mk_stamp(1365, 5, 21, 21, 21));

    for (i = 0; i < RANDOM_STAMPS; i++) begin
      if (i == DRAIN_AT) begin
        stamp_ch.valid <= 1'b0;
        while (board.outstanding() != 0) @(posedge clk);
      end
      send_with_gap(random_stamp());
    end
    stamp_ch.valid <= 1'b0;

    while (board.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.mismatches == 0)
      $display("date_to_minute_count_tb passed");
    else
      $display("date_to_minute_count_tb failed");
    $finish;
  end

endmodule

/* filelist.f */
rtl/dtm_pkg.sv
rtl/dtm_in_if.sv
rtl/dtm_out_if.sv
rtl/dtm_front.sv
rtl/dtm_leap.sv
rtl/dtm_days.sv
rtl/dtm_scale.sv
rtl/date_to_minute_count.sv
rtl/dtm_checker.sv
verif/date_to_minute_count_tb.sv
